>>> rtl/pressed_usage_refcount_table_assert.svh
// Assertion macros of the checker file of the held-usage table.
// Depends on nothing; take it in with `include after the net type line.
`ifndef PRESSED_USAGE_REFCOUNT_TABLE_ASSERT_SVH
`define PRESSED_USAGE_REFCOUNT_TABLE_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define PUR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define PUR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pur_pkg.sv
// Shared types and constants of the held-usage reference-count table.
// Depends on nothing; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package pur_pkg;

  localparam int ID_W             = 16;
  localparam int CNT_W            = 16;
  localparam int STATUS_W         = 3;
  localparam int HELD_W           = 5;
  localparam int KEY_FIELDS       = 6;
  localparam int KEY_IDX_W        = $clog2(KEY_FIELDS);
  localparam int DEF_TABLE_DEPTH  = 16;
  localparam int DEF_REPORT_SLOTS = 6;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

endpackage

`default_nettype wire

>>> rtl/pur_if.sv
// Request and response channel interfaces of the held-usage table.
// Depends on pur_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pur_req_if;
  logic                           valid;
  logic                           ready;
  logic [pur_pkg::ID_W-1:0]       usage_code;
  logic signed [pur_pkg::CNT_W-1:0] count_change;

  modport source (output valid, output usage_code, output count_change, input ready);
  modport sink   (input valid, input usage_code, input count_change, output ready);
endinterface

interface pur_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pur_pkg::STATUS_W-1:0]  status;
  logic [pur_pkg::HELD_W-1:0]    held_count;
  logic [pur_pkg::ID_W-1:0]      report_key_0;
  logic [pur_pkg::ID_W-1:0]      report_key_1;
  logic [pur_pkg::ID_W-1:0]      report_key_2;
  logic [pur_pkg::ID_W-1:0]      report_key_3;
  logic [pur_pkg::ID_W-1:0]      report_key_4;
  logic [pur_pkg::ID_W-1:0]      report_key_5;

  modport source (output valid, output status, output held_count, output report_key_0,
                  output report_key_1, output report_key_2, output report_key_3,
                  output report_key_4, output report_key_5, input ready);
  modport sink   (input valid, input status, input held_count, input report_key_0,
                  input report_key_1, input report_key_2, input report_key_3,
                  input report_key_4, input report_key_5, output ready);
endinterface

`default_nettype wire

>>> rtl/pur_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module pur_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/pressed_usage_refcount_table.sv
// Top level of the held-usage reference-count table with keyboard report.
// Depends on pur_pkg, pur_req_if, pur_rsp_if and pur_ram.
//
//   Channel | Dir | Payload                                   | Per request
//   --------+-----+-------------------------------------------+------------
//   req     | in  | usage_code, count_change                  | one
//   rsp     | out | status, held_count, report_key_0 .. _5    | one
//
// Steps: a request is accepted, searched (skipped with an empty table or a
// zero code) and decided; on insert or remove the entries above the slot
// shift; then the top min(REPORT_SLOTS, 6, held) entries are read for the
// report, and the response is done. A new request is taken only in idle.
// The single read port of the entry RAM reads one entry per cycle.
// Reset: synchronous; clears the held count and all control state, so no RAM
// clearing pass is needed (slots at and above the held count are never read).
// Stalls: a finished response waits in the output register while the next
// request is taken; the sequencer holds in its last state only if that
// register is still full when the following response is ready.
`timescale 1ns / 1ps
`default_nettype none

module pressed_usage_refcount_table #(
  parameter int TABLE_DEPTH  = pur_pkg::DEF_TABLE_DEPTH,
  parameter int REPORT_SLOTS = pur_pkg::DEF_REPORT_SLOTS
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pur_req_if.sink    req,
  pur_rsp_if.source  rsp
);

  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EW    = pur_pkg::ID_W + pur_pkg::CNT_W;
  localparam int KF    = pur_pkg::KEY_FIELDS;
  localparam int KIW   = pur_pkg::KEY_IDX_W;
  localparam int SLOTS = (REPORT_SLOTS < KF) ? REPORT_SLOTS : KF;

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SEARCH = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_SHDN   = 8'b0000_1000,
    S_SHUP   = 8'b0001_0000,
    S_RPREP  = 8'b0010_0000,
    S_REPORT = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t                          state;
  logic [pur_pkg::ID_W-1:0]        code;
  logic signed [pur_pkg::CNT_W-1:0] change;
  logic [CW-1:0]                   total;    // entries held
  logic [CW-1:0]                   idx;      // next RAM read address
  logic [CW-1:0]                   rem;      // reads still to issue
  logic [CW-1:0]                   pos;      // match or insertion slot
  logic                            found;
  logic [pur_pkg::CNT_W-1:0]       cnt;      // count of the matching entry
  logic                            pend;     // read data arrives this cycle
  logic [CW-1:0]                   pend_addr;
  logic [KIW-1:0]                  k;
  logic [KIW-1:0]                  pend_k;
  pur_pkg::status_t                status;
  logic [pur_pkg::ID_W-1:0]        rpt [KF];

  // Output register.
  logic                            rsp_valid;
  logic                            rsp_load;  // finished response enters the register
  pur_pkg::status_t                rsp_status;
  logic [pur_pkg::HELD_W-1:0]      rsp_held;
  logic [pur_pkg::ID_W-1:0]        rsp_key [KF];

  // Entry RAM ports.
  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  logic [EW-1:0]         ram_wr_data;
  logic                  ram_rd_en;
  logic [EW-1:0]         ram_rd_data;

  logic [pur_pkg::ID_W-1:0]  rd_id;
  logic [pur_pkg::CNT_W-1:0] rd_cnt;
  logic [pur_pkg::CNT_W-1:0] new_cnt;
  logic [CW-1:0]             pend_inc;
  logic [CW-1:0]             pend_dec;
  logic                      search_stop;
  logic [CW-1:0]             nrep;

  assign rd_id    = ram_rd_data[EW-1:pur_pkg::CNT_W];
  assign rd_cnt   = ram_rd_data[pur_pkg::CNT_W-1:0];
  assign new_cnt  = cnt + $unsigned(change);
  assign pend_inc = pend_addr + CW'(1);
  assign pend_dec = pend_addr - CW'(1);
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp.ready);

  // Stop the search on the first entry not below the code, or at the last entry.
  assign search_stop = pend && ((rd_id >= code) || (pend_inc == total));

  // Report reads: the top min(SLOTS, total) entries.
  always_comb begin
    if (int'(total) < SLOTS) begin
      nrep = total;
    end else begin
      nrep = CW'(SLOTS);
    end
  end

  // RAM control: read one entry per cycle, write updated counts, moved entries and new entries.
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = pos[AW-1:0];
    ram_wr_data = {code, new_cnt};
    case (state)
      S_SEARCH: begin
        ram_rd_en = (idx < total) && !search_stop;
      end
      S_DECIDE: begin
        ram_wr_en = (code != '0) && found && (new_cnt != '0);
      end
      S_SHDN: begin
        ram_rd_en = (rem != '0);
        if (pend) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = pend_dec[AW-1:0];
          ram_wr_data = ram_rd_data;
        end
      end
      S_SHUP: begin
        ram_rd_en = (rem != '0);
        if (pend) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = pend_inc[AW-1:0];
          ram_wr_data = ram_rd_data;
        end else if (rem == '0) begin
          // Drop the new entry into the gap.
          ram_wr_en   = 1'b1;
          ram_wr_data = {code, $unsigned(change)};
        end
      end
      S_REPORT: begin
        ram_rd_en = (rem != '0);
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  pur_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // Load a finished response, or retire the held one once taken.
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            code  <= req.usage_code;
            change <= req.count_change;
            idx   <= '0;
            pos   <= '0;
            found <= 1'b0;
            pend  <= 1'b0;
            if ((req.usage_code == '0) || (total == '0)) begin
              state <= S_DECIDE;
            end else begin
              state <= S_SEARCH;
            end
          end
        end

        S_SEARCH: begin
          pend      <= ram_rd_en;
          pend_addr <= idx;
          if (ram_rd_en) begin
            idx <= idx + CW'(1);
          end
          if (pend) begin
            if (rd_id < code) begin
              pos <= pend_inc;
            end else begin
              pos   <= pend_addr;
              found <= (rd_id == code);
              cnt   <= rd_cnt;
            end
          end
          if (search_stop) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          pend  <= 1'b0;
          state <= S_RPREP;
          if (code == '0) begin
            status <= pur_pkg::ST_IGNORED;
          end else if (found) begin
            if (new_cnt == '0) begin
              // Close the gap: move the entries above the match down by one.
              status <= pur_pkg::ST_REMOVED;
              idx    <= pos + CW'(1);
              rem    <= total - pos - CW'(1);
              state  <= S_SHDN;
            end else begin
              status <= pur_pkg::ST_UPDATED;
            end
          end else if (change[pur_pkg::CNT_W-1] || (change == '0)) begin
            status <= pur_pkg::ST_IGNORED;
          end else if (int'(total) >= TABLE_DEPTH) begin
            status <= pur_pkg::ST_FULL;
          end else begin
            // Open a gap: move the entries from the top down to pos up by one.
            status <= pur_pkg::ST_INSERTED;
            idx    <= total - CW'(1);
            rem    <= total - pos;
            state  <= S_SHUP;
          end
        end

        S_SHDN: begin
          pend      <= ram_rd_en;
          pend_addr <= idx;
          if (ram_rd_en) begin
            idx <= idx + CW'(1);
            rem <= rem - CW'(1);
          end else if (!pend) begin
            total <= total - CW'(1);
            state <= S_RPREP;
          end
        end

        S_SHUP: begin
          pend      <= ram_rd_en;
          pend_addr <= idx;
          if (ram_rd_en) begin
            idx <= idx - CW'(1);
            rem <= rem - CW'(1);
          end else if (!pend) begin
            total <= total + CW'(1);
            state <= S_RPREP;
          end
        end

        S_RPREP: begin
          for (int i = 0; i < KF; i++) begin
            rpt[i] <= '0;
          end
          idx   <= total - CW'(1);
          rem   <= nrep;
          k     <= '0;
          pend  <= 1'b0;
          state <= S_REPORT;
        end

        S_REPORT: begin
          pend   <= ram_rd_en;
          pend_k <= k;
          if (ram_rd_en) begin
            idx <= idx - CW'(1);
            k   <= k + KIW'(1);
            rem <= rem - CW'(1);
          end
          if (pend) begin
            rpt[pend_k] <= rd_id;
          end
          if (!ram_rd_en && !pend) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // Hold until the output register is free.
          if (rsp_load) begin
            rsp_status <= status;
            rsp_held   <= pur_pkg::HELD_W'(total);
            for (int i = 0; i < KF; i++) begin
              rsp_key[i] <= rpt[i];
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.held_count   = rsp_held;
  assign rsp.report_key_0 = rsp_key[0];
  assign rsp.report_key_1 = rsp_key[1];
  assign rsp.report_key_2 = rsp_key[2];
  assign rsp.report_key_3 = rsp_key[3];
  assign rsp.report_key_4 = rsp_key[4];
  assign rsp.report_key_5 = rsp_key[5];

endmodule

`default_nettype wire

>>> rtl/pur_checker.sv
// Port-level checker of the held-usage table, bound to the top level.
// Depends on pur_pkg and pressed_usage_refcount_table_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "pressed_usage_refcount_table_assert.svh"

module pur_checker #(
  parameter int TABLE_DEPTH = pur_pkg::DEF_TABLE_DEPTH
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         req_valid,
  input wire logic                         req_ready,
  input wire logic                         rsp_valid,
  input wire logic                         rsp_ready,
  input wire logic [pur_pkg::STATUS_W-1:0] status,
  input wire logic [pur_pkg::HELD_W-1:0]   held_count,
  input wire logic [pur_pkg::ID_W-1:0]     key_0,
  input wire logic [pur_pkg::ID_W-1:0]     key_1
);

  // A stalled response holds.
  `PUR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(status) && $stable(held_count) && $stable(key_0),
    "response changed while stalled")

  // The sequencer is busy in the cycle after it takes a request.
  `PUR_ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready,
    "request taken while still working")

  // An insert leaves at least one usage in the report.
  `PUR_ASSERT_NOW(a_insert_reported, clk, rst,
    rsp_valid && (status == pur_pkg::ST_INSERTED), key_0 != '0,
    "inserted usage missing from report")

  // The report lists usages from the highest down.
  `PUR_ASSERT_NOW(a_report_order, clk, rst, rsp_valid && (key_1 != '0), key_0 > key_1,
    "report not in descending order")

  // The held count never exceeds the table depth.
  `PUR_ASSERT_NOW(a_held_bound, clk, rst, rsp_valid, int'(held_count) <= TABLE_DEPTH,
    "held count beyond table depth")

endmodule

bind pressed_usage_refcount_table pur_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_pur_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .held_count (rsp.held_count),
  .key_0      (rsp.report_key_0),
  .key_1      (rsp.report_key_1)
);

`default_nettype wire
